### sv/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants, op codes and channel payload types of the hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 32;
    localparam int COUNT_OUT_BITS = 7;

    localparam int BUCKETS_DEF = 16;
    localparam int WAYS_DEF    = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0]        value;
    } t_req;

    typedef struct packed {
        logic                         success;
        logic [VALUE_BITS-1:0]        value_out;
        logic                         bucket_full;
        logic [COUNT_OUT_BITS-1:0]    entry_count;
        logic                         is_empty;
    } t_rsp;

endpackage

### sv/chm_stream_if.sv
// ----------------------------------------------------------------------------
// chm_stream_if
// Valid/ready channel carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface chm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/chained_hash_map_top.sv
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Key-value map in a bucket RAM; one row holds all ways of a bucket.
// ----------------------------------------------------------------------------
// result: registered after the bucket row read that follows the hash; the hash is
//   combinational for a power-of-two bucket count, else a 3-stage modulo pipeline
// requests: one in flight; the next is taken only after the bucket row read,
//   compare and write back through the single RAM, and a stalled result holds it off
// reset: a clearing pass writes every bucket row, ready low
module chained_hash_map_top #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int WAYS    = chm_pkg::WAYS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    chm_stream_if.sink    i_req,
    chm_stream_if.source  o_rsp
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int KB    = chm_pkg::KEY_BITS;
    localparam int VB    = chm_pkg::VALUE_BITS;
    localparam int OCW   = chm_pkg::COUNT_OUT_BITS;
    localparam int ROW_W = WAYS * (1 + KB + VB);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_LOOK  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [BW-1:0]   r_clr_addr, n_clr_addr;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_vld;
    chm_pkg::t_rsp   r_out, n_rsp;
    logic [1:0]      r_op;
    logic [KB-1:0]   r_key;
    logic [VB-1:0]   r_value;
    logic [BW-1:0]   r_bucket;

    logic            w_accept, w_go;
    logic            w_h_done;
    logic [BW-1:0]   w_h_bucket;
    logic            w_we;
    logic [BW-1:0]   w_waddr;
    logic [ROW_W-1:0] w_wdata, w_rdata;

    logic [WAYS-1:0]         w_vld, n_vld;
    logic [WAYS-1:0][KB-1:0] w_keys, n_keys;
    logic [WAYS-1:0][VB-1:0] w_vals, n_vals;
    logic                    w_hit, w_free, w_mod;
    logic [WW-1:0]           w_hit_idx, w_free_idx;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_go     = (r_state == S_LOOK) && (!r_out_vld || o_rsp.ready);

    chm_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_key    (i_req.data.key),
        .o_done   (w_h_done),
        .o_bucket (w_h_bucket)
    );

    chm_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_h_done),
        .i_raddr (w_h_bucket),
        .o_rdata (w_rdata)
    );

    assign {w_vld, w_keys, w_vals} = w_rdata;

    // lowest matching way and lowest free way of the bucket row
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_vld[w]) begin
                if (w_keys[w] == r_key) begin
                    w_hit     = 1'b1;
                    w_hit_idx = WW'(w);
                end
            end else begin
                w_free     = 1'b1;
                w_free_idx = WW'(w);
            end
        end
    end

    always_comb begin
        n_vld   = w_vld;
        n_keys  = w_keys;
        n_vals  = w_vals;
        n_count = r_count;
        w_mod   = 1'b0;
        n_rsp   = '0;
        unique case (r_op)
            chm_pkg::OP_INSERT: begin
                if (w_hit) begin
                    n_vals[w_hit_idx] = r_value;
                    w_mod             = 1'b1;
                end else if (w_free) begin
                    n_vld[w_free_idx]  = 1'b1;
                    n_keys[w_free_idx] = r_key;
                    n_vals[w_free_idx] = r_value;
                    n_count            = r_count + CW'(1);
                    w_mod              = 1'b1;
                    n_rsp.success      = 1'b1;
                end else begin
                    n_rsp.bucket_full = 1'b1;
                end
            end
            chm_pkg::OP_ERASE: begin
                if (w_hit) begin
                    n_vld[w_hit_idx] = 1'b0;
                    n_count          = r_count - CW'(1);
                    w_mod            = 1'b1;
                    n_rsp.success    = 1'b1;
                end
            end
            chm_pkg::OP_FIND: begin
                if (w_hit) begin
                    n_rsp.success   = 1'b1;
                    n_rsp.value_out = w_vals[w_hit_idx];
                end
            end
            default: begin
            end
        endcase
        n_rsp.entry_count = OCW'(n_count);
        n_rsp.is_empty    = (n_count == '0);
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_go && w_mod;
            w_waddr = r_bucket;
            w_wdata = {n_vld, n_keys, n_vals};
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + BW'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_h_done ? S_LOOK : S_HASH;
                end
            end
            S_HASH: begin
                if (w_h_done) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (w_go) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_req.data.op;
            r_key   <= i_req.data.key;
            r_value <= i_req.data.value;
        end
        if (w_h_done) begin
            r_bucket <= w_h_bucket;
        end
        if (w_go) begin
            r_out <= n_rsp;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

### sv/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/chm_hash.sv
// ----------------------------------------------------------------------------
// chm_hash
// Bucket index: the key sign-extended to 64 bits, unsigned, modulo BUCKETS.
// ----------------------------------------------------------------------------
module chm_hash #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [chm_pkg::KEY_BITS-1:0] i_key,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);

    localparam int BW      = $clog2(BUCKETS);
    localparam int KB      = chm_pkg::KEY_BITS;
    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            // sign extension only sets bits above the bucket field
            assign o_done   = i_start;
            assign o_bucket = i_key[BW-1:0];
        end else begin : g_recip
            localparam int                SHIFT   = KB + BW - 1;
            localparam longint unsigned   RECIP   = (64'd1 << SHIFT) / BUCKETS;
            localparam longint unsigned   P32     = (64'd1 << KB) % BUCKETS;
            localparam longint unsigned   NEG_OFS = (P32 * P32 + BUCKETS - P32) % BUCKETS;

            logic [KB-1:0]   w_recip;
            logic            r_v1, r_v2, r_v3;
            logic [KB-1:0]   r_x1, r_x2;
            logic            r_neg1, r_neg2;
            logic [2*KB-1:0] r_prod;
            logic [KB-1:0]   w_q;
            logic [KB-1:0]   r_qb;
            logic [BW:0]     w_rem;
            logic [BW-1:0]   w_rem1;
            logic [BW:0]     w_sum;
            logic [BW-1:0]   w_bucket;
            logic [BW-1:0]   r_bucket;

            assign w_recip = KB'(RECIP);
            assign w_q     = KB'(r_prod >> SHIFT);

            // quotient estimate is low by at most one, so one correction step
            assign w_rem  = (BW+1)'(r_x2 - r_qb);
            assign w_rem1 = (w_rem >= (BW+1)'(BUCKETS)) ? BW'(w_rem - (BW+1)'(BUCKETS))
                                                         : BW'(w_rem);
            // negative keys carry the upper 32 ones of the extension
            assign w_sum  = {1'b0, w_rem1} + (BW+1)'(NEG_OFS);

            always_comb begin
                if (r_neg2) begin
                    w_bucket = (w_sum >= (BW+1)'(BUCKETS)) ? BW'(w_sum - (BW+1)'(BUCKETS))
                                                            : BW'(w_sum);
                end else begin
                    w_bucket = w_rem1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1 <= 1'b0;
                    r_v2 <= 1'b0;
                    r_v3 <= 1'b0;
                end else begin
                    r_v1 <= i_start;
                    r_v2 <= r_v1;
                    r_v3 <= r_v2;
                end
            end

            always_ff @(posedge i_clk) begin
                r_x1     <= i_key;
                r_neg1   <= i_key[KB-1];
                r_prod   <= (2*KB)'(i_key) * (2*KB)'(w_recip);
                r_x2     <= r_x1;
                r_neg2   <= r_neg1;
                r_qb     <= KB'(w_q * KB'(BUCKETS));
                r_bucket <= w_bucket;
            end

            assign o_done   = r_v3;
            assign o_bucket = r_bucket;
        end
    endgenerate

endmodule

### sv/chm_checker.sv
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks of the hash map, bound to the top level.
// ----------------------------------------------------------------------------
module chm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input chm_pkg::t_rsp i_rsp
);

    // a stalled result stays put
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("result changed while stalled");

    // one request in flight: no accept in the cycle right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.is_empty |-> i_rsp.entry_count == '0)
        else $error("empty map reports entries");

    // full bucket never together with success, a nonzero value only with success
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp.success && i_rsp.bucket_full)
                        && (i_rsp.value_out == '0 || i_rsp.success))
        else $error("inconsistent result flags");

endmodule

bind chained_hash_map_top chm_checker u_chm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);
